// ===== design/assert_macros.svh =====
// Assertion macros shared by the dimmer RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/rsdd_pkg.sv =====
// Package for the RGB sigma-delta LED dimmer: widths, register indexes, types.
// No dependencies.
`default_nettype none
package rsdd_pkg;

    localparam int DUTY_W          = 11;
    localparam int MASK_W          = 3;
    localparam int STAMP_W         = 32;
    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 5;
    localparam int REG_IDX_W       = 3;
    localparam int NUM_CH          = 3;
    localparam int FULL_SCALE_DEF  = 2000;
    localparam int TICK_DIVIDE_DEF = 10;

    localparam logic [REG_IDX_W-1:0] REG_MONO_DUTY  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RED_DUTY   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_DUTY = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_DUTY  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RGB_MODE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_MASK = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TIMER_MODE = 3'd6;

    localparam logic KIND_FAST = 1'b0;

    typedef struct packed {
        logic [DUTY_W-1:0] mono_duty;
        logic [DUTY_W-1:0] red_duty;
        logic [DUTY_W-1:0] green_duty;
        logic [DUTY_W-1:0] blue_duty;
        logic              rgb_mode;
        logic [MASK_W-1:0] color_mask;
        logic              timer_mode;
    } t_cfg;

    // Pulses raised the cycle after a register write lands
    typedef struct packed {
        logic written;
        logic mask_written;
    } t_cfg_evt;

endpackage
`default_nettype wire

// ===== design/rgb_sigma_delta_led_dimmer.sv =====
// Top level of the RGB sigma-delta LED dimmer: input stage, result stage, wiring.
// Depends on rsdd_pkg, rsdd_cfg, rsdd_core and assert_macros.svh.
//
// Three-channel first-order sigma-delta LED dimmer driven by timer ticks. Each
// accepted tick item yields exactly one result item (channel mask, lit flag and
// whether a modulator decision was made). Items are registered on entry and their
// results in an output register; a new item can be taken every cycle while the
// output is not stalled, the rate being set by the combinational accumulator and
// on-flag update in the core.
// Both sides are decoupled by registers, so a stalled output holds at most one
// finished and one pending item. Registers are written over an APB-style port
// at byte address 4*index; duties above full scale saturate. Write registers
// only while no items are in flight. No memories, so no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module rgb_sigma_delta_led_dimmer #(
    parameter int FULL_SCALE  = rsdd_pkg::FULL_SCALE_DEF,
    parameter int TICK_DIVIDE = rsdd_pkg::TICK_DIVIDE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rsdd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [rsdd_pkg::DATA_W-1:0]   pwdata,
    output logic      [rsdd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_kind,
    input  wire logic [rsdd_pkg::STAMP_W-1:0]  i_now_stamp,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [rsdd_pkg::MASK_W-1:0]   o_led_on_mask,
    output logic                               o_lit,
    output logic                               o_decided
);
    rsdd_pkg::t_cfg                 cfg;
    rsdd_pkg::t_cfg_evt             evt;

    logic                           r_in_valid;
    logic                           r_kind;
    logic [rsdd_pkg::STAMP_W-1:0]   r_stamp;
    logic                           r_out_valid;
    logic [rsdd_pkg::MASK_W-1:0]    r_led_on_mask;
    logic                           r_lit;
    logic                           r_decided;

    logic                           out_free;
    logic                           step;
    logic [rsdd_pkg::MASK_W-1:0]    core_mask;
    logic                           core_decided;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    rsdd_cfg #(.FULL_SCALE(FULL_SCALE)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_evt   (evt)
    );

    rsdd_core #(
        .FULL_SCALE  (FULL_SCALE),
        .TICK_DIVIDE (TICK_DIVIDE)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_evt         (evt),
        .i_step        (step),
        .i_kind        (r_kind),
        .i_now_stamp   (r_stamp),
        .o_led_on_mask (core_mask),
        .o_decided     (core_decided)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind  <= i_kind;
            r_stamp <= i_now_stamp;
        end
        if (step) begin
            r_led_on_mask <= core_mask;
            r_lit         <= |core_mask;
            r_decided     <= core_decided;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_on_mask = r_led_on_mask;
    assign o_lit         = r_lit;
    assign o_decided     = r_decided;

    `ASSERT_NEXT(a_pending_kept, i_clk, i_rst_n, r_in_valid && !out_free, r_in_valid)
    `ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, step, r_out_valid)
    `ASSERT_ALWAYS(a_lit_matches, i_clk, i_rst_n, !r_out_valid || (r_lit == (r_led_on_mask != '0)))

endmodule
`default_nettype wire

// ===== design/rsdd_cfg.sv =====
// APB-style configuration registers of the dimmer, with duty saturation.
// Depends on rsdd_pkg.
`default_nettype none
module rsdd_cfg #(
    parameter int FULL_SCALE = rsdd_pkg::FULL_SCALE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rsdd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rsdd_pkg::DATA_W-1:0]  pwdata,
    output logic      [rsdd_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output rsdd_pkg::t_cfg                    o_cfg,
    output rsdd_pkg::t_cfg_evt                o_evt
);
    localparam int FS_W  = $clog2(FULL_SCALE + 1);
    localparam int CMP_W = (FS_W > rsdd_pkg::DUTY_W) ? FS_W : rsdd_pkg::DUTY_W;

    rsdd_pkg::t_cfg                       r_cfg;
    rsdd_pkg::t_cfg_evt                   r_evt;
    logic                                 wr;
    logic [rsdd_pkg::REG_IDX_W-1:0]       idx;
    logic [rsdd_pkg::DUTY_W-1:0]          raw_duty;
    logic [rsdd_pkg::DUTY_W-1:0]          sat_duty;

    assign wr       = psel & penable & pwrite;
    assign idx      = paddr[rsdd_pkg::ADDR_W-1:2];
    assign raw_duty = pwdata[rsdd_pkg::DUTY_W-1:0];
    assign sat_duty = (CMP_W'(raw_duty) > CMP_W'(FULL_SCALE)) ?
                      rsdd_pkg::DUTY_W'(FULL_SCALE) : raw_duty;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_evt <= '0;
        end else begin
            // writes to an unused index leave no event
            r_evt.written      <= wr && (idx <= rsdd_pkg::REG_TIMER_MODE);
            r_evt.mask_written <= wr && (idx == rsdd_pkg::REG_COLOR_MASK);
            if (wr) begin
                case (idx)
                    rsdd_pkg::REG_MONO_DUTY:  r_cfg.mono_duty  <= sat_duty;
                    rsdd_pkg::REG_RED_DUTY:   r_cfg.red_duty   <= sat_duty;
                    rsdd_pkg::REG_GREEN_DUTY: r_cfg.green_duty <= sat_duty;
                    rsdd_pkg::REG_BLUE_DUTY:  r_cfg.blue_duty  <= sat_duty;
                    rsdd_pkg::REG_RGB_MODE:   r_cfg.rgb_mode   <= pwdata[0];
                    rsdd_pkg::REG_COLOR_MASK: r_cfg.color_mask <= pwdata[rsdd_pkg::MASK_W-1:0];
                    rsdd_pkg::REG_TIMER_MODE: r_cfg.timer_mode <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            rsdd_pkg::REG_MONO_DUTY:  prdata = rsdd_pkg::DATA_W'(r_cfg.mono_duty);
            rsdd_pkg::REG_RED_DUTY:   prdata = rsdd_pkg::DATA_W'(r_cfg.red_duty);
            rsdd_pkg::REG_GREEN_DUTY: prdata = rsdd_pkg::DATA_W'(r_cfg.green_duty);
            rsdd_pkg::REG_BLUE_DUTY:  prdata = rsdd_pkg::DATA_W'(r_cfg.blue_duty);
            rsdd_pkg::REG_RGB_MODE:   prdata = rsdd_pkg::DATA_W'(r_cfg.rgb_mode);
            rsdd_pkg::REG_COLOR_MASK: prdata = rsdd_pkg::DATA_W'(r_cfg.color_mask);
            rsdd_pkg::REG_TIMER_MODE: prdata = rsdd_pkg::DATA_W'(r_cfg.timer_mode);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
    assign o_evt = r_evt;

endmodule
`default_nettype wire

// ===== design/rsdd_lane.sv =====
// One first-order sigma-delta step: add duty to error, fire and wrap at full scale.
// Depends on rsdd_pkg.
`default_nettype none
module rsdd_lane #(
    parameter int FULL_SCALE = rsdd_pkg::FULL_SCALE_DEF
) (
    input  wire logic [$clog2(FULL_SCALE)-1:0]  i_err,
    input  wire logic [rsdd_pkg::DUTY_W-1:0]    i_duty,
    output logic      [$clog2(FULL_SCALE)-1:0]  o_err,
    output logic                                o_fire
);
    localparam int ERR_W = $clog2(FULL_SCALE);
    localparam int FS_W  = $clog2(FULL_SCALE + 1);
    localparam int CMP_W = (FS_W > rsdd_pkg::DUTY_W) ? FS_W : rsdd_pkg::DUTY_W;
    localparam int ACC_W = CMP_W + 1;

    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] wrapped;

    assign acc     = ACC_W'(i_err) + ACC_W'(i_duty);
    assign o_fire  = acc >= ACC_W'(FULL_SCALE);
    assign wrapped = acc - ACC_W'(FULL_SCALE);
    // duty never exceeds full scale, so the kept error stays below it
    assign o_err   = o_fire ? wrapped[ERR_W-1:0] : acc[ERR_W-1:0];

endmodule
`default_nettype wire

// ===== design/rsdd_core.sv =====
// Dimmer state: tick divider, accumulators, on flag and mask; one tick per cycle while stepped.
// Depends on rsdd_pkg, rsdd_lane and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rsdd_core #(
    parameter int FULL_SCALE  = rsdd_pkg::FULL_SCALE_DEF,
    parameter int TICK_DIVIDE = rsdd_pkg::TICK_DIVIDE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rsdd_pkg::t_cfg                i_cfg,
    input  wire rsdd_pkg::t_cfg_evt            i_evt,
    input  wire logic                          i_step,
    input  wire logic                          i_kind,
    input  wire logic [rsdd_pkg::STAMP_W-1:0]  i_now_stamp,
    output logic      [rsdd_pkg::MASK_W-1:0]   o_led_on_mask,
    output logic                               o_decided
);
    localparam int ERR_W = $clog2(FULL_SCALE);
    localparam int FS_W  = $clog2(FULL_SCALE + 1);
    localparam int CMP_W = (FS_W > rsdd_pkg::DUTY_W) ? FS_W : rsdd_pkg::DUTY_W;
    localparam int DIV_W = $clog2(TICK_DIVIDE + 1);

    logic [ERR_W-1:0]              r_fast_err, n_fast_err;
    logic [ERR_W-1:0]              r_slow_err, n_slow_err;
    logic [ERR_W-1:0]              r_ch_err [rsdd_pkg::NUM_CH];
    logic [ERR_W-1:0]              n_ch_err [rsdd_pkg::NUM_CH];
    logic [DIV_W-1:0]              r_div, n_div;
    logic [rsdd_pkg::STAMP_W-1:0]  r_last, n_last;
    logic                          r_on, n_on;
    logic [rsdd_pkg::MASK_W-1:0]   r_mask, n_mask;

    logic [rsdd_pkg::DUTY_W-1:0]   ch_duty [rsdd_pkg::NUM_CH];
    logic [ERR_W-1:0]              ch_next [rsdd_pkg::NUM_CH];
    logic [rsdd_pkg::NUM_CH-1:0]   ch_fire;
    logic [ERR_W-1:0]              mono_err, mono_next;
    logic                          mono_fire;
    logic                          enabled;
    logic                          duty_full;
    logic [DIV_W-1:0]              div_inc;
    logic                          dec;
    logic                          on_base;
    logic [rsdd_pkg::MASK_W-1:0]   mask_base;

    assign ch_duty[0] = i_cfg.red_duty;
    assign ch_duty[1] = i_cfg.green_duty;
    assign ch_duty[2] = i_cfg.blue_duty;

    assign enabled = i_cfg.rgb_mode ?
                     |{i_cfg.red_duty, i_cfg.green_duty, i_cfg.blue_duty} :
                     |i_cfg.mono_duty;
    assign duty_full = CMP_W'(i_cfg.mono_duty) >= CMP_W'(FULL_SCALE);
    assign div_inc   = r_div + DIV_W'(1);
    assign mono_err  = (i_kind == rsdd_pkg::KIND_FAST) ? r_fast_err : r_slow_err;

    rsdd_lane #(.FULL_SCALE(FULL_SCALE)) u_mono_lane (
        .i_err  (mono_err),
        .i_duty (i_cfg.mono_duty),
        .o_err  (mono_next),
        .o_fire (mono_fire)
    );

    for (genvar g = 0; g < rsdd_pkg::NUM_CH; g++) begin : g_ch
        rsdd_lane #(.FULL_SCALE(FULL_SCALE)) u_lane (
            .i_err  (r_ch_err[g]),
            .i_duty (ch_duty[g]),
            .o_err  (ch_next[g]),
            .o_fire (ch_fire[g])
        );
    end

    always_comb begin
        // register write effects land first, a decision in the same cycle sees them
        on_base   = r_on;
        mask_base = r_mask;
        if (i_evt.written) begin
            if (i_evt.mask_written && enabled && r_on) begin
                mask_base = i_cfg.color_mask;
            end
            if (!enabled) begin
                on_base   = 1'b0;
                mask_base = '0;
            end
        end

        n_fast_err = r_fast_err;
        n_slow_err = r_slow_err;
        n_ch_err   = r_ch_err;
        n_div      = r_div;
        n_last     = r_last;
        n_on       = on_base;
        n_mask     = mask_base;
        dec        = 1'b0;

        if (i_step && enabled) begin
            if (i_kind == rsdd_pkg::KIND_FAST) begin
                if (div_inc == DIV_W'(TICK_DIVIDE)) begin
                    n_div = '0;
                    dec   = 1'b1;
                end else begin
                    n_div = div_inc;
                end
            end else if (!i_cfg.timer_mode && !i_cfg.rgb_mode && i_now_stamp != r_last) begin
                n_last = i_now_stamp;
                dec    = 1'b1;
            end
        end

        if (dec) begin
            if (i_cfg.rgb_mode) begin
                n_ch_err = ch_next;
                n_mask   = ch_fire & i_cfg.color_mask;
                n_on     = |(ch_fire & i_cfg.color_mask);
            end else if (duty_full) begin
                // full duty: force on, accumulator untouched
                if (!on_base) begin
                    n_on   = 1'b1;
                    n_mask = i_cfg.color_mask;
                end
            end else begin
                if (i_kind == rsdd_pkg::KIND_FAST) begin
                    n_fast_err = mono_next;
                end else begin
                    n_slow_err = mono_next;
                end
                if (mono_fire != on_base) begin
                    n_on   = mono_fire;
                    n_mask = mono_fire ? i_cfg.color_mask : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_err <= '0;
            r_slow_err <= '0;
            r_ch_err   <= '{default: '0};
            r_div      <= '0;
            r_last     <= '0;
            r_on       <= 1'b0;
            r_mask     <= '0;
        end else begin
            r_fast_err <= n_fast_err;
            r_slow_err <= n_slow_err;
            r_ch_err   <= n_ch_err;
            r_div      <= n_div;
            r_last     <= n_last;
            r_on       <= n_on;
            r_mask     <= n_mask;
        end
    end

    assign o_led_on_mask = n_on ? n_mask : '0;
    assign o_decided     = dec;

    `ASSERT_ALWAYS(a_div_range, i_clk, i_rst_n, r_div < DIV_W'(TICK_DIVIDE))
    `ASSERT_ALWAYS(a_fast_err_range, i_clk, i_rst_n, (FS_W)'(r_fast_err) < (FS_W)'(FULL_SCALE))
    `ASSERT_ALWAYS(a_off_no_mask, i_clk, i_rst_n, r_on || (r_mask == '0))
    `ASSERT_NEXT(a_idle_holds_div, i_clk, i_rst_n, !i_step, r_div == $past(r_div))

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for rgb_sigma_delta_led_dimmer: directed and random tick items,
// APB register writes and a per-item predictor of the three-channel modulator.
// Depends on rsdd_pkg and the dimmer RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rsdd_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic KIND_MSEC = ~rsdd_pkg::KIND_FAST;
    localparam int   ITEM_TARGET = 1000;

    typedef struct packed {
        logic [rsdd_pkg::MASK_W-1:0] mask;
        logic                        lit;
        logic                        decided;
    } t_led_result;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [rsdd_pkg::ADDR_W-1:0]      paddr;
    logic [rsdd_pkg::DATA_W-1:0]      pwdata;
    logic [rsdd_pkg::DATA_W-1:0]      prdata;
    logic                             pready;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic                             i_kind;
    logic [rsdd_pkg::STAMP_W-1:0]     i_now_stamp;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [rsdd_pkg::MASK_W-1:0]      o_led_on_mask;
    logic                             o_lit;
    logic                             o_decided;

    rgb_sigma_delta_led_dimmer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_now_stamp   (i_now_stamp),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_led_on_mask (o_led_on_mask),
        .o_lit         (o_lit),
        .o_decided     (o_decided)
    );

    // Predictor state: register copies and modulator state
    logic [rsdd_pkg::DUTY_W-1:0]   duty_mono, duty_red, duty_green, duty_blue;
    logic                          rgb_sel, timer_sel;
    logic [rsdd_pkg::MASK_W-1:0]   mask_sel;
    int                            fast_err, slow_err;
    int                            chan_err [rsdd_pkg::NUM_CH];
    int                            div_count;
    logic [rsdd_pkg::STAMP_W-1:0]  last_stamp_seen;
    logic                          led_on;
    logic [rsdd_pkg::MASK_W-1:0]   led_mask;

    t_led_result                   led_results_due [$];
    int                            mismatch_count;
    logic                          sender_gaps;
    logic                          sink_stalls;
    logic [rsdd_pkg::STAMP_W-1:0]  stamp_cursor;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic void reset_dimmer_model();
        duty_mono = '0;
        duty_red = '0;
        duty_green = '0;
        duty_blue = '0;
        rgb_sel = 1'b0;
        timer_sel = 1'b0;
        mask_sel = '0;
        fast_err = 0;
        slow_err = 0;
        for (int i = 0; i < rsdd_pkg::NUM_CH; i++) chan_err[i] = 0;
        div_count = 0;
        last_stamp_seen = '0;
        led_on = 1'b0;
        led_mask = '0;
    endfunction

    function automatic logic dimmer_enabled();
        if (rgb_sel)
            return (duty_red | duty_green | duty_blue) != '0;
        return duty_mono != '0;
    endfunction

    function automatic logic [rsdd_pkg::DUTY_W-1:0] clamp_duty(
        input logic [rsdd_pkg::DATA_W-1:0] v);
        logic [rsdd_pkg::DUTY_W-1:0] d;
        d = v[rsdd_pkg::DUTY_W-1:0];
        return (d > rsdd_pkg::FULL_SCALE_DEF) ?
               (rsdd_pkg::DUTY_W)'(rsdd_pkg::FULL_SCALE_DEF) : d;
    endfunction

    function automatic void mirror_reg_write(input logic [rsdd_pkg::REG_IDX_W-1:0] idx,
                                             input logic [rsdd_pkg::DATA_W-1:0] v);
        case (idx)
            rsdd_pkg::REG_MONO_DUTY:  duty_mono = clamp_duty(v);
            rsdd_pkg::REG_RED_DUTY:   duty_red = clamp_duty(v);
            rsdd_pkg::REG_GREEN_DUTY: duty_green = clamp_duty(v);
            rsdd_pkg::REG_BLUE_DUTY:  duty_blue = clamp_duty(v);
            rsdd_pkg::REG_RGB_MODE:   rgb_sel = v[0];
            rsdd_pkg::REG_COLOR_MASK: begin
                mask_sel = v[rsdd_pkg::MASK_W-1:0];
                if (dimmer_enabled() && led_on)
                    led_mask = mask_sel;
            end
            rsdd_pkg::REG_TIMER_MODE: timer_sel = v[0];
            default: return;
        endcase
        if (!dimmer_enabled()) begin
            led_on = 1'b0;
            led_mask = '0;
        end
    endfunction

    // One single-duty decision; returns the updated accumulator
    function automatic int mono_decision(input int err);
        int   acc;
        logic hit;
        if (duty_mono >= rsdd_pkg::FULL_SCALE_DEF) begin
            // full duty: latch on, accumulator untouched
            if (!led_on) begin
                led_on = 1'b1;
                led_mask = mask_sel;
            end
            return err;
        end
        acc = err + int'(duty_mono);
        hit = acc >= rsdd_pkg::FULL_SCALE_DEF;
        if (hit)
            acc = acc - rsdd_pkg::FULL_SCALE_DEF;
        if (hit != led_on) begin
            led_on = hit;
            led_mask = hit ? mask_sel : '0;
        end
        return acc;
    endfunction

    function automatic void rgb_decision();
        logic [rsdd_pkg::DUTY_W-1:0] duty;
        logic [rsdd_pkg::MASK_W-1:0] lit_mask;
        lit_mask = '0;
        for (int i = 0; i < rsdd_pkg::NUM_CH; i++) begin
            duty = (i == 0) ? duty_red : (i == 1) ? duty_green : duty_blue;
            chan_err[i] = chan_err[i] + int'(duty);
            if (chan_err[i] >= rsdd_pkg::FULL_SCALE_DEF) begin
                chan_err[i] = chan_err[i] - rsdd_pkg::FULL_SCALE_DEF;
                if (mask_sel[i])
                    lit_mask[i] = 1'b1;
            end
        end
        led_mask = lit_mask;
        led_on = lit_mask != '0;
    endfunction

    function automatic t_led_result predict_tick(input logic kind,
                                                 input logic [rsdd_pkg::STAMP_W-1:0] stamp);
        t_led_result r;
        logic        decided;
        decided = 1'b0;
        if (dimmer_enabled()) begin
            if (kind == rsdd_pkg::KIND_FAST) begin
                div_count++;
                if (div_count >= rsdd_pkg::TICK_DIVIDE_DEF) begin
                    div_count = 0;
                    decided = 1'b1;
                    if (rgb_sel)
                        rgb_decision();
                    else
                        fast_err = mono_decision(fast_err);
                end
            end else if (!timer_sel && !rgb_sel && stamp != last_stamp_seen) begin
                last_stamp_seen = stamp;
                decided = 1'b1;
                slow_err = mono_decision(slow_err);
            end
        end
        r.mask = led_on ? led_mask : '0;
        r.lit = r.mask != '0;
        r.decided = decided;
        return r;
    endfunction

    // ---------------- drivers ----------------

    task automatic apb_write(input logic [rsdd_pkg::REG_IDX_W-1:0] idx,
                             input logic [rsdd_pkg::DATA_W-1:0] v);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        mirror_reg_write(idx, v);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_tick(input logic kind, input logic [rsdd_pkg::STAMP_W-1:0] stamp);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_kind = kind;
        i_now_stamp = stamp;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        led_results_due.push_back(predict_tick(kind, stamp));
    endtask

    task automatic hold_off(input int cycles);
        if (cycles == 0)
            return;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stop sending and wait until every result is back
    task automatic drain_all();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (led_results_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin : out_stall
        int stall_left;
        int r;
        stall_left = 0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!sink_stalls) begin
                i_out_ready = 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    i_out_ready = 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else if (r < 15) begin
                    i_out_ready = 1'b0;
                    stall_left = $urandom_range(8, 40);
                end else begin
                    i_out_ready = 1'b1;
                end
            end
        end
    end

    // ---------------- checking ----------------

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_led_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (led_results_due.size() == 0) begin
                flag_mismatch("result with no item pending",
                              32'({o_led_on_mask, o_lit, o_decided}), 32'h0);
            end else begin
                want = led_results_due.pop_front();
                if (o_led_on_mask !== want.mask)
                    flag_mismatch("led_on_mask", 32'(o_led_on_mask), 32'(want.mask));
                if (o_lit !== want.lit)
                    flag_mismatch("lit", 32'(o_lit), 32'(want.lit));
                if (o_decided !== want.decided)
                    flag_mismatch("decided", 32'(o_decided), 32'(want.decided));
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_disabled_after_reset();
        send_tick(rsdd_pkg::KIND_FAST, $urandom);
        send_tick(KIND_MSEC, 32'd5);     // ignored: last stamp stays zero
        drain_all();
    endtask

    task automatic test_mono_full_duty();
        apb_write(rsdd_pkg::REG_MONO_DUTY, 32'h0000_07FF);   // saturates to full scale
        apb_write(rsdd_pkg::REG_COLOR_MASK, 32'd5);
        send_tick(KIND_MSEC, 32'h0);             // same as reset stamp
        send_tick(KIND_MSEC, 32'hFFFF_FFFF);
        send_tick(KIND_MSEC, 32'hFFFF_FFFF);     // repeated stamp
        drain_all();
        apb_write(rsdd_pkg::REG_COLOR_MASK, 32'd2);        // mask swap while lit
        send_tick(KIND_MSEC, 32'd1);
        drain_all();
        apb_write(rsdd_pkg::REG_COLOR_MASK, 32'd0);        // on but nothing shown
        send_tick(KIND_MSEC, 32'd2);
        drain_all();
    endtask

    task automatic test_disable_and_bad_index();
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        apb_write(rsdd_pkg::REG_MONO_DUTY, 32'h0000_1000); // low bits zero: disables
        send_tick(rsdd_pkg::KIND_FAST, $urandom);
        drain_all();
    endtask

    task automatic test_mono_fast_ticks();
        apb_write(rsdd_pkg::REG_MONO_DUTY, 32'd1);
        apb_write(rsdd_pkg::REG_COLOR_MASK, 32'd7);
        repeat (rsdd_pkg::TICK_DIVIDE_DEF) send_tick(rsdd_pkg::KIND_FAST, $urandom);
        drain_all();
    endtask

    task automatic test_rgb_channels();
        apb_write(rsdd_pkg::REG_RED_DUTY, 32'hFFFF_F7D0);  // upper bits dropped
        apb_write(rsdd_pkg::REG_GREEN_DUTY, 32'd1999);
        apb_write(rsdd_pkg::REG_BLUE_DUTY, 32'd1);
        apb_write(rsdd_pkg::REG_COLOR_MASK, 32'd3);
        apb_write(rsdd_pkg::REG_RGB_MODE, 32'd1);
        send_tick(KIND_MSEC, 32'd100);           // ms ticks ignored in rgb mode
        repeat (rsdd_pkg::TICK_DIVIDE_DEF) send_tick(rsdd_pkg::KIND_FAST, $urandom);
        drain_all();
    endtask

    task automatic test_timer_mode();
        apb_write(rsdd_pkg::REG_RGB_MODE, 32'd0);
        apb_write(rsdd_pkg::REG_TIMER_MODE, 32'd1);
        send_tick(KIND_MSEC, 32'd200);
        drain_all();
    endtask

    function automatic logic [rsdd_pkg::DATA_W-1:0] pick_duty();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd1999;
            3: return 32'd2000;
            4: return 32'd2047;
            5: return $urandom;
            default: return $urandom_range(0, rsdd_pkg::FULL_SCALE_DEF);
        endcase
    endfunction

    task automatic randomise_registers();
        int                             start;
        logic [rsdd_pkg::REG_IDX_W-1:0] idx;
        start = $urandom_range(0, 6);
        for (int k = 0; k < 7; k++) begin
            idx = (rsdd_pkg::REG_IDX_W)'((start + k) % 7);
            if ($urandom_range(0, 4) != 0) begin
                if (idx == rsdd_pkg::REG_RGB_MODE || idx == rsdd_pkg::REG_COLOR_MASK ||
                    idx == rsdd_pkg::REG_TIMER_MODE)
                    apb_write(idx, $urandom);
                else
                    apb_write(idx, pick_duty());
            end
        end
        if ($urandom_range(0, 7) == 0)
            apb_write(REG_UNUSED, $urandom);
    endtask

    task automatic test_random_traffic();
        int                           sent;
        int                           phase;
        int                           phase_len;
        logic                         kind;
        logic [rsdd_pkg::STAMP_W-1:0] stamp;
        sent = 0;
        phase = 0;
        stamp_cursor = 32'd1000;
        while (sent < ITEM_TARGET) begin
            drain_all();
            randomise_registers();
            sender_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
            sink_stalls = (phase != 0) && ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(60, 120);
            repeat (phase_len) begin
                kind = 1'($urandom_range(0, 1));
                if (kind == rsdd_pkg::KIND_FAST) begin
                    stamp = $urandom;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: begin
                            stamp_cursor = stamp_cursor + $urandom_range(1, 3);
                            stamp = stamp_cursor;
                        end
                        6, 7: stamp = last_stamp_seen;
                        default: stamp = $urandom;
                    endcase
                end
                if (sender_gaps)
                    hold_off(pick_gap());
                send_tick(kind, stamp);
                sent++;
                if ($urandom_range(0, 49) == 0)
                    drain_all();
            end
            phase++;
        end
        drain_all();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_kind = rsdd_pkg::KIND_FAST;
        i_now_stamp = '0;
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        mismatch_count = 0;
        reset_dimmer_model();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_disabled_after_reset();
        test_mono_full_duty();
        test_disable_and_bad_index();
        test_mono_fast_ticks();
        test_rgb_channels();
        test_timer_mode();
        test_random_traffic();

        drain_all();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/rsdd_pkg.sv
design/rsdd_cfg.sv
design/rsdd_lane.sv
design/rsdd_core.sv
design/rgb_sigma_delta_led_dimmer.sv
tb/sv/tb_top.sv
